### src/gwm_pkg.sv
`default_nettype none

package gwm_pkg;

  // Store sizes
  localparam int unsigned PatternDepth = 64;
  localparam int unsigned TextDepth    = 256;

  // Length counters hold the depth itself, addresses index the stores
  localparam int unsigned PLenW  = $clog2(PatternDepth + 1);
  localparam int unsigned TLenW  = $clog2(TextDepth + 1);
  localparam int unsigned PAddrW = (PatternDepth > 1) ? $clog2(PatternDepth) : 1;
  localparam int unsigned TAddrW = (TextDepth > 1) ? $clog2(TextDepth) : 1;

  localparam int unsigned ByteW = 8;

  // Wildcard bytes
  localparam logic [ByteW-1:0] ChAny = 8'h3F;
  localparam logic [ByteW-1:0] ChRun = 8'h2A;

  typedef enum logic [1:0] {
    KindClrPat  = 2'd0,
    KindAppPat  = 2'd1,
    KindAppText = 2'd2,
    KindEval    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StRead = 2'd1,
    StCmp  = 2'd2,
    StDone = 2'd3
  } state_e;

endpackage

`default_nettype wire

### src/glob_wildcard_matcher_unit.sv
// Loads (clear pattern, append pattern byte, append text byte) leave the sequencer idle.
// Each evaluation match step passes through a store read state, then a compare state,
// and the result is shown in a done state; steps grow up to about pattern length times
// text length on backtracks. An overflowed evaluation goes straight to the done state.
// The result strobe lasts one cycle and the receiver cannot stall it. Reset clears
// lengths, flags and the sequencer state, not the working positions or byte stores.
`default_nettype none

module glob_wildcard_matcher_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] byte_value_i,
  output logic            done_o,
  output logic            matched_o,
  output logic            overflowed_o
);

  localparam int unsigned PLenW  = gwm_pkg::PLenW;
  localparam int unsigned TLenW  = gwm_pkg::TLenW;
  localparam int unsigned PAddrW = gwm_pkg::PAddrW;
  localparam int unsigned TAddrW = gwm_pkg::TAddrW;

  gwm_pkg::state_e state_q, state_d;

  logic [PLenW-1:0] plen_q, plen_d;
  logic             povf_q, povf_d;
  logic [TLenW-1:0] tlen_q, tlen_d;
  logic             tovf_q, tovf_d;

  logic [PLenW-1:0] p_q, p_d;
  logic [PLenW-1:0] run_pos_q, run_pos_d;
  logic             have_run_q, have_run_d;
  logic [TLenW-1:0] t_q, t_d;
  logic [TLenW-1:0] resume_q, resume_d;

  logic matched_q, matched_d;
  logic ovf_q, ovf_d;

  logic                   pat_we, text_we;
  logic [gwm_pkg::ByteW-1:0] pat_rdata, text_rdata;

  logic xfer;
  logic p_in, t_in, pat_hit, pat_run, p_full, t_full;

  assign xfer   = start && (state_q == gwm_pkg::StIdle);
  assign p_full = (plen_q == PLenW'(gwm_pkg::PatternDepth));
  assign t_full = (tlen_q == TLenW'(gwm_pkg::TextDepth));

  assign pat_we  = xfer && (gwm_pkg::kind_e'(kind_i) == gwm_pkg::KindAppPat) && !p_full;
  assign text_we = xfer && (gwm_pkg::kind_e'(kind_i) == gwm_pkg::KindAppText) && !t_full;

  gwm_ram #(
    .Width (gwm_pkg::ByteW),
    .Depth (gwm_pkg::PatternDepth)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (plen_q[PAddrW-1:0]),
    .wdata_i (byte_value_i),
    .raddr_i (p_q[PAddrW-1:0]),
    .rdata_o (pat_rdata)
  );

  gwm_ram #(
    .Width (gwm_pkg::ByteW),
    .Depth (gwm_pkg::TextDepth)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (tlen_q[TAddrW-1:0]),
    .wdata_i (byte_value_i),
    .raddr_i (t_q[TAddrW-1:0]),
    .rdata_o (text_rdata)
  );

  // Compare terms on the registered store reads
  assign p_in    = (p_q < plen_q);
  assign t_in    = (t_q < tlen_q);
  assign pat_hit = p_in && ((pat_rdata == gwm_pkg::ChAny) || (pat_rdata == text_rdata));
  assign pat_run = p_in && (pat_rdata == gwm_pkg::ChRun);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gwm_pkg::StIdle: begin
        if (xfer && (gwm_pkg::kind_e'(kind_i) == gwm_pkg::KindEval)) begin
          state_d = (povf_q || tovf_q) ? gwm_pkg::StDone : gwm_pkg::StRead;
        end
      end
      gwm_pkg::StRead: begin
        state_d = gwm_pkg::StCmp;
      end
      gwm_pkg::StCmp: begin
        if (t_in) begin
          state_d = (pat_hit || pat_run || have_run_q) ? gwm_pkg::StRead : gwm_pkg::StDone;
        end else begin
          state_d = pat_run ? gwm_pkg::StRead : gwm_pkg::StDone;
        end
      end
      gwm_pkg::StDone: begin
        state_d = gwm_pkg::StIdle;
      end
      default: begin
        state_d = gwm_pkg::StIdle;
      end
    endcase
  end

  // Datapath updates
  always_comb begin
    plen_d     = plen_q;
    povf_d     = povf_q;
    tlen_d     = tlen_q;
    tovf_d     = tovf_q;
    p_d        = p_q;
    run_pos_d  = run_pos_q;
    have_run_d = have_run_q;
    t_d        = t_q;
    resume_d   = resume_q;
    matched_d  = matched_q;
    ovf_d      = ovf_q;
    case (state_q)
      gwm_pkg::StIdle: begin
        if (xfer) begin
          case (gwm_pkg::kind_e'(kind_i))
            gwm_pkg::KindClrPat: begin
              plen_d = '0;
              povf_d = 1'b0;
            end
            gwm_pkg::KindAppPat: begin
              if (p_full) povf_d = 1'b1;
              else        plen_d = plen_q + PLenW'(1);
            end
            gwm_pkg::KindAppText: begin
              if (t_full) tovf_d = 1'b1;
              else        tlen_d = tlen_q + TLenW'(1);
            end
            gwm_pkg::KindEval: begin
              p_d        = '0;
              t_d        = '0;
              have_run_d = 1'b0;
              matched_d  = 1'b0;
              ovf_d      = povf_q || tovf_q;
            end
            default: begin
              plen_d = plen_q;
            end
          endcase
        end
      end
      gwm_pkg::StCmp: begin
        if (t_in) begin
          if (pat_hit) begin
            // Advance both on a literal or any-byte match
            t_d = t_q + TLenW'(1);
            p_d = p_q + PLenW'(1);
          end else if (pat_run) begin
            // Record the backtrack point
            have_run_d = 1'b1;
            run_pos_d  = p_q;
            p_d        = p_q + PLenW'(1);
            resume_d   = t_q;
          end else if (have_run_q) begin
            // Let the run swallow one more byte
            p_d      = run_pos_q + PLenW'(1);
            resume_d = resume_q + TLenW'(1);
            t_d      = resume_q + TLenW'(1);
          end else begin
            matched_d = 1'b0;
          end
        end else begin
          // Skip trailing runs, then require the pattern to be used up
          if (pat_run) p_d = p_q + PLenW'(1);
          else         matched_d = (p_q == plen_q);
        end
      end
      gwm_pkg::StDone: begin
        // Drop the text after each evaluation
        tlen_d = '0;
        tovf_d = 1'b0;
      end
      default: begin
        p_d = p_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gwm_pkg::StIdle;
      plen_q     <= '0;
      povf_q     <= 1'b0;
      tlen_q     <= '0;
      tovf_q     <= 1'b0;
      have_run_q <= 1'b0;
      matched_q  <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      plen_q     <= plen_d;
      povf_q     <= povf_d;
      tlen_q     <= tlen_d;
      tovf_q     <= tovf_d;
      have_run_q <= have_run_d;
      matched_q  <= matched_d;
      ovf_q      <= ovf_d;
    end
  end

  // Sequencer working registers
  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    run_pos_q <= run_pos_d;
    t_q       <= t_d;
    resume_q  <= resume_d;
  end

  // Outputs
  always_comb begin
    busy         = (state_q != gwm_pkg::StIdle);
    done_o       = (state_q == gwm_pkg::StDone);
    matched_o    = matched_q;
    overflowed_o = ovf_q;
  end

endmodule

`default_nettype wire

### src/gwm_ram.sv
`default_nettype none

module gwm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                             wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
